@@ rtl/core/crc_checked_frame_deframer_unit_macros.svh @@
// Assertion helpers shared by the deframer modules.
// Each macro expands to one labeled concurrent assertion on the rising clock edge,
// disabled while reset is high.
`ifndef CRC_CHECKED_FRAME_DEFRAMER_UNIT_MACROS_SVH
`define CRC_CHECKED_FRAME_DEFRAMER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFD_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define CFD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

@@ rtl/core/cfd_pkg.sv @@
package cfd_pkg;

   // Header layout, by byte position within the 80-byte header.
   localparam logic [6:0] POS_FORMAT = 7'd4;
   localparam logic [6:0] POS_TYPE   = 7'd6;
   localparam logic [6:0] POS_FLAGS  = 7'd8;
   localparam logic [6:0] POS_RSVD   = 7'd10;
   localparam logic [6:0] POS_LENGTH = 7'd12;
   localparam logic [6:0] POS_HCRC   = 7'd16;
   localparam logic [6:0] POS_PCRC   = 7'd20;
   localparam logic [6:0] POS_IDS    = 7'd24;
   localparam logic [6:0] HDR_LAST   = 7'd79;

   // The five 64-bit identifiers start at 64-bit word three of the header.
   localparam int NUM_IDS       = 5;
   localparam int ID_FIRST_WORD = 3;

   localparam logic [15:0] TYPE_LIMIT = 16'd12;

   // CRC-32C, reflected form.
   localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   // Result data bus: 395 bits of fields rounded up to whole bytes.
   localparam int RSP_FIELD_W = 395;
   localparam int RSP_DATA_W  = 400;
   localparam int RSP_PAD_W   = RSP_DATA_W - RSP_FIELD_W;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_FAILED  = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_INTEGRITY   = 3'd1,
      ST_UNSUPPORTED = 3'd2,
      ST_MALFORMED   = 3'd3,
      ST_OVERSIZED   = 3'd4
   } status_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_STATUS  = 1'b1
   } kind_type;

   typedef enum logic {
      CMD_DATA    = 1'b0,
      CMD_RESTART = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_MAGIC    = 2'd0,
      CSR_FORMAT   = 2'd1,
      CSR_MAX_LEN  = 2'd2,
      CSR_RSVD_MSK = 2'd3
   } csr_index_type;

   // One result item as it waits in the output queue.
   typedef struct packed {
      kind_type                    kind;
      logic [7:0]                  payload_byte;
      logic                        last;
      status_type                  status;
      logic [15:0]                 frame_type;
      logic [15:0]                 frame_flags;
      logic [31:0]                 payload_length;
      logic [NUM_IDS-1:0][63:0]    ids;
   } rec_type;

   // One byte step of the reflected CRC-32C.
   function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'h00_0000, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

@@ rtl/core/crc_checked_frame_deframer_unit.sv @@
// Byte-serial deframer for length-prefixed frames guarded by CRC-32C.
// Input channel (req_): one transfer per stream byte; req_tuser is the command,
// 0 for a data byte in req_tdata, 1 for a restart that clears a failure and
// returns to the start of a header. Output channel (rsp_): one transfer per
// result; rsp_tuser is 0 for a passed payload byte and 1 for a frame status
// record, which also raises rsp_tlast and carries the captured header fields.
// Configuration (csr_): a single-cycle write of magic, format version, payload
// limit or reserved-flag mask; the user must see that it is written only while
// no traffic is in flight, as the block does not enforce it. With an empty queue
// a result is offered on rsp_ the cycle after its input transfer; a payload's
// status record sits right behind its last payload byte. One byte per cycle is
// taken while the output queue has space for two records (a frame's last
// payload byte and its status record come from one transfer); the queue drains
// one record per cycle while rsp_tready is high. When rsp_ stalls, req_tready
// drops once over QUEUE_DEPTH - 2 records wait, so at most QUEUE_DEPTH pile up.
// Reset clears the parser to the header start and empties the queue; the
// configuration registers return to their defaults.
`include "crc_checked_frame_deframer_unit_macros.svh"

module crc_checked_frame_deframer_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   // Input stream
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // data_byte
   input  logic                           req_tuser,   // cmd
   // Result stream
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // payload_byte, status, frame_type, frame_flags, payload_length, epoch_id,
   // boot_id, publisher_id, connection_id, sequence_number, zero pad
   output logic [cfd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast,   // last_of_frame
   output logic                           rsp_tuser,   // out_kind
   // Configuration writes
   input  logic                           csr_we,
   input  cfd_pkg::csr_index_type         csr_addr,
   input  logic [31:0]                    csr_wdata
);
   import cfd_pkg::*;

   // Configuration registers
   logic [31:0] cfg_magic_ff;
   logic [15:0] cfg_format_ff;
   logic [31:0] cfg_max_len_ff;
   logic [15:0] cfg_rsvd_mask_ff;

   // Parser state
   phase_type   phase_ff, phase_in;
   logic [6:0]  pos_ff, pos_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] crc_ff, crc_in;

   // Captured header fields
   logic [31:0]              magic_ff, magic_in;
   logic [15:0]              format_ff, format_in;
   logic [15:0]              type_ff, type_in;
   logic [15:0]              flags_ff, flags_in;
   logic [31:0]              length_ff, length_in;
   logic [31:0]              hcrc_ff, hcrc_in;
   logic [31:0]              pcrc_ff, pcrc_in;
   logic [NUM_IDS-1:0][63:0] ids_ff, ids_in;

   // Step signals
   logic        take;
   logic        take_data;
   logic        hdr_take;
   logic        hdr_done;
   logic        restart_take;
   logic        at_frame_start;
   logic [7:0]  crc_data;
   logic [31:0] crc_step;
   logic [31:0] end_crc;
   logic [31:0] rem_dec;
   status_type  hdr_status;
   status_type  end_status;
   status_type  rec_status;

   // Queue interface
   logic        room;
   logic [1:0]  push;
   rec_type     push_rec0;
   rec_type     push_rec1;
   rec_type     stat_rec;
   rec_type     byte_rec;
   rec_type     head;

   assign take      = req_tvalid && req_tready;
   assign take_data = take && (req_tuser == CMD_DATA);
   assign hdr_take  = take_data && (phase_ff == PH_HEADER);
   assign hdr_done  = (pos_ff == HDR_LAST);
   assign req_tready = room;
   assign restart_take   = take && (req_tuser == CMD_RESTART);
   assign at_frame_start = (phase_ff == PH_HEADER) && (pos_ff == '0) && (crc_ff == CRC_INIT);

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_magic_ff     <= 32'h0000_0000;
         cfg_format_ff    <= 16'd1;
         cfg_max_len_ff   <= 32'd65536;
         cfg_rsvd_mask_ff <= 16'h0003;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_MAGIC:    cfg_magic_ff     <= csr_wdata;
            CSR_FORMAT:   cfg_format_ff    <= csr_wdata[15:0];
            CSR_MAX_LEN:  cfg_max_len_ff   <= csr_wdata;
            CSR_RSVD_MSK: cfg_rsvd_mask_ff <= csr_wdata[15:0];
         endcase
      end
   end

   // CRC over the current byte; the stored header CRC bytes count as zero.
   assign crc_data = (phase_ff == PH_HEADER && pos_ff >= POS_HCRC && pos_ff < POS_PCRC) ?
                     8'h00 : req_tdata;
   assign crc_step = crc32c_byte(crc_ff, crc_data);
   assign rem_dec  = rem_ff - 32'd1;

   // Header checks in priority order; the last header byte adds no field.
   always_comb begin
      priority if (((crc_step ^ CRC_INIT) != hcrc_ff) || (magic_ff != cfg_magic_ff)) begin
         hdr_status = ST_INTEGRITY;
      end else if (format_ff != cfg_format_ff) begin
         hdr_status = ST_UNSUPPORTED;
      end else if ((type_ff == 16'd0) || (type_ff >= TYPE_LIMIT)) begin
         hdr_status = ST_MALFORMED;
      end else if (length_ff > cfg_max_len_ff) begin
         hdr_status = ST_OVERSIZED;
      end else begin
         hdr_status = ST_OK;
      end
   end

   // Frame end checks; an empty payload has a CRC of zero.
   assign end_crc = (phase_ff == PH_HEADER) ? 32'h0000_0000 : (crc_step ^ CRC_INIT);

   always_comb begin
      priority if ((flags_ff & cfg_rsvd_mask_ff) != 16'h0000) begin
         end_status = ST_UNSUPPORTED;
      end else if (end_crc != pcrc_ff) begin
         end_status = ST_INTEGRITY;
      end else begin
         end_status = ST_OK;
      end
   end

   // Next parser state
   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      rem_in   = rem_ff;
      crc_in   = crc_ff;
      if (take && req_tuser == CMD_RESTART) begin
         phase_in = PH_HEADER;
         pos_in   = '0;
         rem_in   = '0;
         crc_in   = CRC_INIT;
      end else if (take) begin
         unique case (phase_ff)
            PH_HEADER: begin
               crc_in = crc_step;
               if (!hdr_done) begin
                  pos_in = pos_ff + 7'd1;
               end else begin
                  pos_in = '0;
                  if (hdr_status != ST_OK) begin
                     phase_in = PH_FAILED;
                  end else begin
                     crc_in = CRC_INIT;
                     if (length_ff == '0) begin
                        phase_in = (end_status != ST_OK) ? PH_FAILED : PH_HEADER;
                     end else begin
                        rem_in   = length_ff;
                        phase_in = PH_PAYLOAD;
                     end
                  end
               end
            end
            PH_PAYLOAD: begin
               crc_in = crc_step;
               rem_in = rem_dec;
               if (rem_dec == '0) begin
                  if (end_status != ST_OK) begin
                     phase_in = PH_FAILED;
                  end else begin
                     phase_in = PH_HEADER;
                     crc_in   = CRC_INIT;
                  end
               end
            end
            default: begin
               // Failed: data bytes are dropped.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         pos_ff   <= '0;
         rem_ff   <= '0;
         crc_ff   <= CRC_INIT;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         rem_ff   <= rem_in;
         crc_ff   <= crc_in;
      end
   end

   // Header field capture, one byte lane per position.
   always_comb begin
      magic_in  = magic_ff;
      format_in = format_ff;
      type_in   = type_ff;
      flags_in  = flags_ff;
      length_in = length_ff;
      hcrc_in   = hcrc_ff;
      pcrc_in   = pcrc_ff;
      ids_in    = ids_ff;
      if (hdr_take) begin
         if (pos_ff < POS_FORMAT) begin
            magic_in[{pos_ff[1:0], 3'b000} +: 8] = req_tdata;
         end else if (pos_ff < POS_TYPE) begin
            format_in[{pos_ff[0], 3'b000} +: 8] = req_tdata;
         end else if (pos_ff < POS_FLAGS) begin
            type_in[{pos_ff[0], 3'b000} +: 8] = req_tdata;
         end else if (pos_ff < POS_RSVD) begin
            flags_in[{pos_ff[0], 3'b000} +: 8] = req_tdata;
         end else if (pos_ff >= POS_LENGTH && pos_ff < POS_HCRC) begin
            length_in[{pos_ff[1:0], 3'b000} +: 8] = req_tdata;
         end else if (pos_ff >= POS_HCRC && pos_ff < POS_PCRC) begin
            hcrc_in[{pos_ff[1:0], 3'b000} +: 8] = req_tdata;
         end else if (pos_ff >= POS_PCRC && pos_ff < POS_IDS) begin
            pcrc_in[{pos_ff[1:0], 3'b000} +: 8] = req_tdata;
         end else begin
            // Identifier words cover positions 24 to 63; the rest is CRC only.
            for (int i = 0; i < NUM_IDS; i++) begin
               if (pos_ff[6:3] == 4'(ID_FIRST_WORD + i)) begin
                  ids_in[i][{pos_ff[2:0], 3'b000} +: 8] = req_tdata;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff  <= '0;
         format_ff <= '0;
         type_ff   <= '0;
         flags_ff  <= '0;
         length_ff <= '0;
         hcrc_ff   <= '0;
         pcrc_ff   <= '0;
         ids_ff    <= '0;
      end else begin
         magic_ff  <= magic_in;
         format_ff <= format_in;
         type_ff   <= type_in;
         flags_ff  <= flags_in;
         length_ff <= length_in;
         hcrc_ff   <= hcrc_in;
         pcrc_ff   <= pcrc_in;
         ids_ff    <= ids_in;
      end
   end

   // Result records
   assign rec_status = (phase_ff == PH_HEADER && hdr_status != ST_OK) ? hdr_status : end_status;

   always_comb begin
      stat_rec                = '0;
      stat_rec.kind           = KIND_STATUS;
      stat_rec.last           = 1'b1;
      stat_rec.status         = rec_status;
      stat_rec.frame_type     = type_ff;
      stat_rec.frame_flags    = flags_ff;
      stat_rec.payload_length = length_ff;
      stat_rec.ids            = ids_ff;
      byte_rec                = '0;
      byte_rec.kind           = KIND_PAYLOAD;
      byte_rec.payload_byte   = req_tdata;
      byte_rec.status         = ST_OK;
   end

   // Queue pushes for the current transfer
   always_comb begin
      push      = 2'b00;
      push_rec0 = stat_rec;
      push_rec1 = stat_rec;
      if (take_data) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (hdr_done && (hdr_status != ST_OK || length_ff == '0)) begin
                  push[0] = 1'b1;
               end
            end
            PH_PAYLOAD: begin
               push[0]   = 1'b1;
               push_rec0 = byte_rec;
               push[1]   = (rem_dec == '0);
            end
            default: begin
               push = 2'b00;
            end
         endcase
      end
   end

   cfd_rsp_queue #(
      .DEPTH     (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_rec0 (push_rec0),
      .push_rec1 (push_rec1),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rec   (head)
   );

   // Output channel packing
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;
   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, head.ids, head.payload_length, head.frame_flags,
                       head.frame_type, head.status, head.payload_byte};

   `CFD_ASSERT_IMPLY(a_payload_has_bytes, clock, reset, phase_ff == PH_PAYLOAD, rem_ff != '0)
   `CFD_ASSERT_IMPLY(a_pos_in_header, clock, reset, pos_ff != '0, phase_ff == PH_HEADER)
   `CFD_ASSERT_NEXT(a_restart, clock, reset, restart_take, at_frame_start)

endmodule

@@ rtl/core/cfd_rsp_queue.sv @@
`include "crc_checked_frame_deframer_unit_macros.svh"

module cfd_rsp_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [1:0]        push,       // bit 0: first record, bit 1: second record
   input  cfd_pkg::rec_type  push_rec0,
   input  cfd_pkg::rec_type  push_rec1,
   output logic              room,       // space for two more records
   output logic              out_valid,
   input  logic              out_ready,
   output cfd_pkg::rec_type  out_rec
);
   import cfd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rec_type            slots_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [PTR_W-1:0]   wr_alt;
   logic               pop;
   logic [CNT_W-1:0]   n_push;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign out_valid = (count_ff != '0);
   assign out_rec   = slots_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   assign room      = (count_ff <= CNT_W'(DEPTH - 2));
   assign wr_alt    = ptr_next(wr_ptr_ff);
   assign n_push    = CNT_W'(push[0]) + CNT_W'(push[1]);

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push[1]) begin
         wr_ptr_in = ptr_next(wr_alt);
      end else if (push[0]) begin
         wr_ptr_in = wr_alt;
      end
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + n_push - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Record storage; the second record of a pair lands in the slot after the first.
   always_ff @(posedge clock) begin
      if (push[0]) begin
         slots_ff[wr_ptr_ff] <= push_rec0;
      end
      if (push[1]) begin
         slots_ff[wr_alt] <= push_rec1;
      end
   end

   `CFD_ASSERT_IMPLY(a_push_order, clock, reset, push[1], push[0])
   `CFD_ASSERT_IMPLY(a_no_overflow, clock, reset, push[0], count_ff <= CNT_W'(DEPTH - 2))
   `CFD_ASSERT_NEXT(a_empty_stays, clock, reset, count_ff == '0 && push == 2'b00, !out_valid)

endmodule
